// ----- sv/tph_pkg.sv -----
// package for the transition pair histogram
// shared types, field widths and codes; no dependencies
`timescale 1ns / 1ps

package tph_pkg;

   localparam int NUM_BITS  = 15;
   localparam int KEY_BITS  = 2 * NUM_BITS;
   localparam int MODE_BITS = 2;
   localparam int KIND_BITS = 2;
   localparam int OUT_COUNT_BITS = 16;
   localparam int DUMP_INDEX_BITS = 10;

   localparam logic [NUM_BITS-1:0] LIMIT_RESET = NUM_BITS'(128);

   localparam logic [MODE_BITS-1:0] MODE_NUMBER     = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR      = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_RESET_PRED = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_DUMP       = 2'd3;

   localparam logic [KIND_BITS-1:0] KIND_COUNTED = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FULL    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DUMPED  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_DUMP_RD,
      ST_DUMP_CAP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]      kind;
      logic [NUM_BITS-1:0]       from_number;
      logic [NUM_BITS-1:0]       to_number;
      logic [OUT_COUNT_BITS-1:0] pair_count;
   } rsp_beat_type;

endpackage

// ----- sv/transition_pair_histogram.sv -----
// a counted result passes ST_SCAN (one table read per stored entry, ends early on a match),
// ST_UPDATE and ST_DONE into the tph_out register; a full result skips ST_UPDATE;
// a dump result passes ST_DUMP_RD, ST_DUMP_CAP and ST_DONE; clear, predecessor reset, first number give none
// throughput: next beat taken the cycle after the result is pushed, a stalled result holds it;
// beats without a result do not stall the input; reset: synchronous; clears predecessor, entry count and
// limit (to 128); table contents are kept, no clearing pass; uses tph_pkg, tph_seq, tph_table_ram, tph_out
`timescale 1ns / 1ps

module transition_pair_histogram #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int COUNT_MAX     = 65535,
   parameter int LIMIT_CEILING = 16384
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tph_pkg::MODE_BITS-1:0]       req_mode,
   input  logic signed [31:0]                  req_number_value,
   input  logic [tph_pkg::DUMP_INDEX_BITS-1:0] req_dump_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tph_pkg::KIND_BITS-1:0]       rsp_result_kind,
   output logic [tph_pkg::NUM_BITS-1:0]        rsp_from_number,
   output logic [tph_pkg::NUM_BITS-1:0]        rsp_to_number,
   output logic [tph_pkg::OUT_COUNT_BITS-1:0]  rsp_pair_count,
   input  logic                                csr_write_enable,
   input  logic [tph_pkg::NUM_BITS-1:0]        csr_write_data
);

   localparam int IndexWidth = $clog2(TABLE_ENTRIES);
   localparam int CountWidth = $clog2(64'(COUNT_MAX) + 64'd1);
   localparam int EntryWidth = tph_pkg::KEY_BITS + CountWidth;

   logic                  mem_wr_en;
   logic [IndexWidth-1:0] mem_wr_addr;
   logic [EntryWidth-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [IndexWidth-1:0] mem_rd_addr;
   logic [EntryWidth-1:0] mem_rd_data;
   logic                  out_free;
   logic                  out_push;
   tph_pkg::rsp_beat_type out_beat;

   tph_seq #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .COUNT_MAX     (COUNT_MAX),
      .LIMIT_CEILING (LIMIT_CEILING),
      .INDEX_WIDTH   (IndexWidth),
      .COUNT_WIDTH   (CountWidth),
      .ENTRY_WIDTH   (EntryWidth)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_number_value (req_number_value),
      .req_dump_index   (req_dump_index),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .out_free         (out_free),
      .out_push         (out_push),
      .out_beat         (out_beat)
   );

   tph_table_ram #(
      .DEPTH      (TABLE_ENTRIES),
      .WIDTH      (EntryWidth),
      .ADDR_WIDTH (IndexWidth)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   tph_out u_out (
      .clock           (clock),
      .reset           (reset),
      .push            (out_push),
      .beat            (out_beat),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_from_number (rsp_from_number),
      .rsp_to_number   (rsp_to_number),
      .rsp_pair_count  (rsp_pair_count)
   );

endmodule

// ----- sv/tph_table_ram.sv -----
// pair table storage: one write port, one read port, registered read data
// no package dependencies
`timescale 1ns / 1ps

module tph_table_ram #(
   parameter int DEPTH      = 1024,
   parameter int WIDTH      = 47,
   parameter int ADDR_WIDTH = 10
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tph_seq.sv -----
// sequencer: input beats, limit register, predecessor, table scan and update
// uses tph_pkg; drives the table memory ports and the result register
`timescale 1ns / 1ps

module tph_seq #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int COUNT_MAX     = 65535,
   parameter int LIMIT_CEILING = 16384,
   parameter int INDEX_WIDTH   = 10,
   parameter int COUNT_WIDTH   = 16,
   parameter int ENTRY_WIDTH   = 46
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tph_pkg::MODE_BITS-1:0]        req_mode,
   input  logic signed [31:0]                   req_number_value,
   input  logic [tph_pkg::DUMP_INDEX_BITS-1:0]  req_dump_index,
   input  logic                                 csr_write_enable,
   input  logic [tph_pkg::NUM_BITS-1:0]         csr_write_data,
   output logic                                 mem_wr_en,
   output logic [INDEX_WIDTH-1:0]               mem_wr_addr,
   output logic [ENTRY_WIDTH-1:0]               mem_wr_data,
   output logic                                 mem_rd_en,
   output logic [INDEX_WIDTH-1:0]               mem_rd_addr,
   input  logic [ENTRY_WIDTH-1:0]               mem_rd_data,
   input  logic                                 out_free,
   output logic                                 out_push,
   output tph_pkg::rsp_beat_type                out_beat
);

   localparam int UsedWidth = $clog2(TABLE_ENTRIES + 1);

   tph_pkg::state_type state_ff, state_in;

   logic [tph_pkg::NUM_BITS-1:0] limit_ff, limit_in;
   logic [tph_pkg::NUM_BITS-1:0] last_ff;
   logic                         have_last_ff;
   logic [UsedWidth-1:0]         used_ff;
   logic [tph_pkg::KEY_BITS-1:0] key_ff;
   logic [UsedWidth-1:0]         scan_ff;
   logic                         cmp_valid_ff;
   logic [INDEX_WIDTH-1:0]       cmp_addr_ff;
   logic [INDEX_WIDTH-1:0]       wr_addr_ff;
   logic [COUNT_WIDTH-1:0]       wr_count_ff;
   logic                         insert_ff;
   logic [INDEX_WIDTH-1:0]       dump_addr_ff;
   tph_pkg::rsp_beat_type        beat_ff;

   logic [tph_pkg::NUM_BITS-1:0] cur_num;
   logic                         accept;
   logic                         scan_rd;
   logic                         match;
   logic                         scan_end;
   logic                         full;
   logic                         dump_ok;
   logic [tph_pkg::KEY_BITS-1:0] rd_key;
   logic [COUNT_WIDTH-1:0]       rd_count;
   logic [COUNT_WIDTH-1:0]       inc_count;

   // limit write with clamping into 1..ceiling
   always_comb begin
      if (csr_write_data == '0) begin
         limit_in = tph_pkg::NUM_BITS'(1);
      end else if (32'(csr_write_data) > 32'(LIMIT_CEILING)) begin
         limit_in = tph_pkg::NUM_BITS'(LIMIT_CEILING);
      end else begin
         limit_in = csr_write_data;
      end
   end

   // clip the incoming number into 0..limit
   always_comb begin
      if (req_number_value[31]) begin
         cur_num = '0;
      end else if ($unsigned(req_number_value) > 32'(limit_ff)) begin
         cur_num = limit_ff;
      end else begin
         cur_num = req_number_value[tph_pkg::NUM_BITS-1:0];
      end
   end

   assign accept    = (state_ff == tph_pkg::ST_IDLE) && req_valid;
   assign req_stall = (state_ff != tph_pkg::ST_IDLE);

   assign rd_key    = mem_rd_data[ENTRY_WIDTH-1 -: tph_pkg::KEY_BITS];
   assign rd_count  = mem_rd_data[COUNT_WIDTH-1:0];
   assign inc_count = (rd_count < COUNT_WIDTH'(COUNT_MAX)) ?
                      COUNT_WIDTH'(rd_count + 1'b1) : rd_count;
   assign scan_rd   = (state_ff == tph_pkg::ST_SCAN) && (scan_ff < used_ff);
   assign match     = cmp_valid_ff && (rd_key == key_ff);
   assign scan_end  = !scan_rd && !cmp_valid_ff;
   assign full      = 32'(used_ff) >= 32'(TABLE_ENTRIES);
   assign dump_ok   = 32'(req_dump_index) < 32'(used_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tph_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == tph_pkg::MODE_NUMBER && have_last_ff) begin
                  state_in = tph_pkg::ST_SCAN;
               end else if (req_mode == tph_pkg::MODE_DUMP && dump_ok) begin
                  state_in = tph_pkg::ST_DUMP_RD;
               end
            end
         end
         tph_pkg::ST_SCAN: begin
            if (match) begin
               state_in = tph_pkg::ST_UPDATE;
            end else if (scan_end) begin
               state_in = full ? tph_pkg::ST_DONE : tph_pkg::ST_UPDATE;
            end
         end
         tph_pkg::ST_UPDATE:   state_in = tph_pkg::ST_DONE;
         tph_pkg::ST_DUMP_RD:  state_in = tph_pkg::ST_DUMP_CAP;
         tph_pkg::ST_DUMP_CAP: state_in = tph_pkg::ST_DONE;
         tph_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = tph_pkg::ST_IDLE;
            end
         end
         default: state_in = tph_pkg::ST_IDLE;
      endcase
   end

   // memory and result controls
   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = scan_ff[INDEX_WIDTH-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = wr_addr_ff;
      mem_wr_data = {key_ff, wr_count_ff};
      out_push    = 1'b0;
      case (state_ff)
         tph_pkg::ST_SCAN: begin
            mem_rd_en = scan_rd;
         end
         tph_pkg::ST_DUMP_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = dump_addr_ff;
         end
         tph_pkg::ST_UPDATE: begin
            mem_wr_en = 1'b1;
         end
         tph_pkg::ST_DONE: begin
            out_push = out_free;
         end
         default: begin
            mem_rd_en = 1'b0;
         end
      endcase
   end

   assign out_beat = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tph_pkg::ST_IDLE;
         limit_ff     <= tph_pkg::LIMIT_RESET;
         last_ff      <= '0;
         have_last_ff <= 1'b0;
         used_ff      <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            limit_ff <= limit_in;
         end
         case (state_ff)
            tph_pkg::ST_IDLE: begin
               if (accept) begin
                  case (req_mode)
                     tph_pkg::MODE_NUMBER: begin
                        last_ff      <= cur_num;
                        have_last_ff <= 1'b1;
                        key_ff       <= {last_ff, cur_num};
                        scan_ff      <= '0;
                        cmp_valid_ff <= 1'b0;
                     end
                     tph_pkg::MODE_CLEAR:      used_ff      <= '0;
                     tph_pkg::MODE_RESET_PRED: have_last_ff <= 1'b0;
                     tph_pkg::MODE_DUMP: begin
                        dump_addr_ff <= INDEX_WIDTH'(req_dump_index);
                     end
                     default: have_last_ff <= have_last_ff;
                  endcase
               end
            end
            tph_pkg::ST_SCAN: begin
               cmp_valid_ff <= scan_rd;
               cmp_addr_ff  <= scan_ff[INDEX_WIDTH-1:0];
               if (scan_rd) begin
                  scan_ff <= UsedWidth'(scan_ff + 1'b1);
               end
               if (match) begin
                  wr_addr_ff  <= cmp_addr_ff;
                  wr_count_ff <= inc_count;
                  insert_ff   <= 1'b0;
               end else if (scan_end) begin
                  if (full) begin
                     beat_ff <= '{kind: tph_pkg::KIND_FULL,
                                  from_number: key_ff[tph_pkg::KEY_BITS-1 -: tph_pkg::NUM_BITS],
                                  to_number: key_ff[tph_pkg::NUM_BITS-1:0],
                                  pair_count: '0};
                  end else begin
                     wr_addr_ff  <= used_ff[INDEX_WIDTH-1:0];
                     wr_count_ff <= COUNT_WIDTH'(1);
                     insert_ff   <= 1'b1;
                  end
               end
            end
            tph_pkg::ST_UPDATE: begin
               if (insert_ff) begin
                  used_ff <= UsedWidth'(used_ff + 1'b1);
               end
               beat_ff <= '{kind: tph_pkg::KIND_COUNTED,
                            from_number: key_ff[tph_pkg::KEY_BITS-1 -: tph_pkg::NUM_BITS],
                            to_number: key_ff[tph_pkg::NUM_BITS-1:0],
                            pair_count: tph_pkg::OUT_COUNT_BITS'(wr_count_ff)};
            end
            tph_pkg::ST_DUMP_CAP: begin
               beat_ff <= '{kind: tph_pkg::KIND_DUMPED,
                            from_number: rd_key[tph_pkg::KEY_BITS-1 -: tph_pkg::NUM_BITS],
                            to_number: rd_key[tph_pkg::NUM_BITS-1:0],
                            pair_count: tph_pkg::OUT_COUNT_BITS'(rd_count)};
            end
            default: begin
               cmp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

// ----- sv/tph_out.sv -----
// result register between the sequencer and the rsp channel
// uses tph_pkg for the beat type
`timescale 1ns / 1ps

module tph_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  tph_pkg::rsp_beat_type               beat,
   output logic                                free,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tph_pkg::KIND_BITS-1:0]       rsp_result_kind,
   output logic [tph_pkg::NUM_BITS-1:0]        rsp_from_number,
   output logic [tph_pkg::NUM_BITS-1:0]        rsp_to_number,
   output logic [tph_pkg::OUT_COUNT_BITS-1:0]  rsp_pair_count
);

   logic                  valid_ff;
   tph_pkg::rsp_beat_type beat_ff;

   assign free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (push) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         beat_ff <= beat;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = beat_ff.kind;
   assign rsp_from_number = beat_ff.from_number;
   assign rsp_to_number   = beat_ff.to_number;
   assign rsp_pair_count  = beat_ff.pair_count;

endmodule

// ----- sv/tph_checker.sv -----
// port-level checks for transition_pair_histogram, attached by bind
// uses tph_pkg for widths and result codes
`timescale 1ns / 1ps

module tph_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [tph_pkg::KIND_BITS-1:0]       rsp_result_kind,
   input logic [tph_pkg::NUM_BITS-1:0]        rsp_from_number,
   input logic [tph_pkg::NUM_BITS-1:0]        rsp_to_number,
   input logic [tph_pkg::OUT_COUNT_BITS-1:0]  rsp_pair_count
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_from_number) && $stable(rsp_to_number) && $stable(rsp_pair_count))
      else $error("stalled rsp beat changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_kind == tph_pkg::KIND_COUNTED
         || rsp_result_kind == tph_pkg::KIND_FULL
         || rsp_result_kind == tph_pkg::KIND_DUMPED)
      else $error("undefined result kind");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == tph_pkg::KIND_FULL |-> rsp_pair_count == '0)
      else $error("full result with nonzero count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == tph_pkg::KIND_COUNTED |-> rsp_pair_count != '0)
      else $error("counted pair with zero count");

endmodule

bind transition_pair_histogram tph_checker u_tph_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_from_number (rsp_from_number),
   .rsp_to_number   (rsp_to_number),
   .rsp_pair_count  (rsp_pair_count)
);
